/* rtl/bilrs_pkg.sv */
package bilrs_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int FRAC_BITS  = 8;

    localparam int DEPTH   = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int IPART_W = 16 - FRAC_BITS;
    localparam int NB_W    = IPART_W + 1;
    localparam int CMP_W   = 16;
    localparam int WGT_W   = FRAC_BITS + 1;
    localparam int PROD_W  = 2 * FRAC_BITS + 1;
    localparam int ACC_W   = 2 * FRAC_BITS + 8;

    localparam logic [WGT_W-1:0] ONE_WGT = WGT_W'(1) << FRAC_BITS;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic        action;
        logic [7:0]  pixel_col;
        logic [7:0]  pixel_row;
        logic [31:0] pixel_value;
        logic [15:0] sample_x;
        logic [15:0] sample_y;
    } t_in;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_out;

endpackage

/* rtl/bilinear_rgba_sampler.sv */
// Channel   Signals                                   Direction  Accept
// item      start, busy, i_item                       in         start && !busy
// result    o_result_valid, o_result                  out        one cycle strobe
// config    i_cfg_valid, o_cfg_ready, i_cfg_index,    in         valid && ready
//           i_cfg_data
//
// A write beat stores its pixel at the accept edge.
// A sample beat holds busy while it makes four reads of the single-port image
// memory, one per cycle, each accumulated in the cycle after it by one shared
// multiply-accumulate lane per channel; the result strobe follows in the next cycle.
// Reset is synchronous, active low; the image memory is not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
module bilinear_rgba_sampler
    import bilrs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in                  i_item,
    output logic                 o_result_valid,
    output t_out                 o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [8:0]           i_cfg_data
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;
    localparam logic [2:0] LAST_STEP = 3'd4;

    logic                 r_state;
    logic [2:0]           r_step;
    logic [8:0]           r_width;
    logic [8:0]           r_height;
    logic [IPART_W-1:0]   r_ix;
    logic [IPART_W-1:0]   r_iy;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;
    logic [PROD_W-1:0]    r_weight;
    logic                 r_nvalid;
    logic [ACC_W-1:0]     r_acc [4];
    logic [ACC_W-1:0]     n_acc [4];
    logic                 r_res_valid;
    t_out                 r_result;

    logic                 accept;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [NB_W-1:0]      nb_col;
    logic [NB_W-1:0]      nb_row;
    logic                 nb_valid;
    logic [ADDR_W-1:0]    rd_addr;
    logic [WGT_W-1:0]     wx;
    logic [WGT_W-1:0]     wy;
    logic                 mac_en;
    logic                 issue;
    logic [ADDR_W-1:0]    ram_addr;
    logic [31:0]          ram_rdata;
    logic [7:0]           chan [4];
    logic [8+PROD_W-1:0]  prod [4];

    assign busy        = (r_state == S_RUN);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign wr_en = accept && (i_item.action == ACT_WRITE)
                   && (CMP_W'(i_item.pixel_col) < CMP_W'(MAX_WIDTH))
                   && (CMP_W'(i_item.pixel_row) < CMP_W'(MAX_HEIGHT));
    assign wr_addr = ADDR_W'(i_item.pixel_row) * ADDR_W'(MAX_WIDTH)
                     + ADDR_W'(i_item.pixel_col);

    // step bit 0 picks the right column, bit 1 the lower row
    assign nb_col = {1'b0, r_ix} + NB_W'(r_step[0]);
    assign nb_row = {1'b0, r_iy} + NB_W'(r_step[1]);
    assign nb_valid = (CMP_W'(nb_col) < CMP_W'(r_width))
                      && (CMP_W'(nb_col) < CMP_W'(MAX_WIDTH))
                      && (CMP_W'(nb_row) < CMP_W'(r_height))
                      && (CMP_W'(nb_row) < CMP_W'(MAX_HEIGHT));
    assign rd_addr = ADDR_W'(nb_row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(nb_col);

    assign wx = r_step[0] ? {1'b0, r_fx} : ONE_WGT - {1'b0, r_fx};
    assign wy = r_step[1] ? {1'b0, r_fy} : ONE_WGT - {1'b0, r_fy};

    assign issue    = busy && (r_step < LAST_STEP);
    assign mac_en   = busy && (r_step != 3'd0);
    assign ram_addr = busy ? rd_addr : wr_addr;

    bilrs_ram #(
        .WIDTH(32),
        .DEPTH(DEPTH)
    ) u_image (
        .i_clk  (i_clk),
        .i_we   (wr_en),
        .i_addr (ram_addr),
        .i_wdata(i_item.pixel_value),
        .o_rdata(ram_rdata)
    );

    // lane 0 is red in the top byte, lane 3 alpha in the bottom byte
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            chan[k]  = r_nvalid ? ram_rdata[8*(3-k) +: 8] : 8'd0;
            prod[k]  = (8+PROD_W)'(chan[k]) * (8+PROD_W)'(r_weight);
            n_acc[k] = r_acc[k] + prod[k][ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= 3'd0;
            r_res_valid <= 1'b0;
            r_width     <= 9'd256;
            r_height    <= 9'd256;
        end else begin
            r_res_valid <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (accept && (i_item.action == ACT_SAMPLE)) begin
                        r_state <= S_RUN;
                        r_step  <= 3'd0;
                    end
                end
                S_RUN: begin
                    if (r_step == LAST_STEP) begin
                        r_state     <= S_IDLE;
                        r_res_valid <= 1'b1;
                    end
                    r_step <= r_step + 3'd1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && (i_item.action == ACT_SAMPLE)) begin
            r_ix <= i_item.sample_x[15 -: IPART_W];
            r_iy <= i_item.sample_y[15 -: IPART_W];
            r_fx <= i_item.sample_x[FRAC_BITS-1:0];
            r_fy <= i_item.sample_y[FRAC_BITS-1:0];
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= '0;
            end
        end
        if (issue) begin
            r_weight <= PROD_W'(wx) * PROD_W'(wy);
            r_nvalid <= nb_valid;
        end
        if (mac_en) begin
            for (int k = 0; k < 4; k++) begin
                r_acc[k] <= n_acc[k];
            end
        end
        if (busy && (r_step == LAST_STEP)) begin
            r_result.red   <= n_acc[0][ACC_W-1 -: 8];
            r_result.green <= n_acc[1][ACC_W-1 -: 8];
            r_result.blue  <= n_acc[2][ACC_W-1 -: 8];
            r_result.alpha <= n_acc[3][ACC_W-1 -: 8];
        end
    end

    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

`ifndef ASSERT_OFF
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_result_valid)
        else $error("busy dropped without a result strobe");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_sample_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_SAMPLE) |=> (busy && r_step == 3'd0))
        else $error("accepted sample did not start the sequencer");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_item.action == ACT_WRITE) |=> (!busy && !o_result_valid))
        else $error("write beat produced a result or held busy");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_step <= LAST_STEP))
        else $error("sequencer step out of range");
`endif

endmodule

/* rtl/bilrs_ram.sv */
module bilrs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
